FILE: src/tunnel_message_reassembler_unit_macros.svh
// Assertion macros shared by the tunnel message reassembler.
`ifndef TUNNEL_MESSAGE_REASSEMBLER_UNIT_MACROS_SVH
`define TUNNEL_MESSAGE_REASSEMBLER_UNIT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define TMR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define TMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tmr_pkg.sv
// Types and constants of the tunnel message reassembler.
package tmr_pkg;

  localparam int FRAME_BYTES       = 60;
  localparam int READ_BUFFER_BYTES = 256;
  localparam int HEADER_BYTES      = 2;

  localparam int CAP_W  = 9;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  localparam logic [CAP_W-1:0] CAP_MAX     = CAP_W'(READ_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_FULL    = LEN_W'(FRAME_BYTES);
  localparam logic [LEN_W-1:0] LEN_HEADER  = LEN_W'(HEADER_BYTES);

  typedef enum logic {
    CMD_ARM  = 1'b0,
    CMD_BYTE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_ABANDON  = 2'd2
  } kind_t;

  typedef enum logic {
    REG_CHANNEL  = 1'b0,
    REG_PROTOCOL = 1'b1
  } reg_index_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  write_offset;
    logic [BYTE_W-1:0]  write_data;
    logic [CAP_W-1:0]   total_size;
    logic [BYTE_W-1:0]  source_id;
    logic [BYTE_W-1:0]  destination_id;
    logic               last;
  } result_t;

endpackage

FILE: src/tunnel_message_reassembler_unit.sv
// Top level of the tunnel message reassembler: frame parsing and result buffer.
//
// The slave stream carries one command per transfer: tuser low arms a new
// read with the capacity in tdata, tuser high delivers one byte of a tunnel
// frame with its length, protocol and channel. The master stream carries the
// results: payload byte writes, read completions and read abandons, with
// tlast marking the final result caused by one input transfer.
// Each input is decoded in the cycle it is accepted; its results appear on
// the master side in the next cycle.
// An input causes at most two results. A two-entry result buffer holds them,
// and a new input is taken whenever the buffer is empty or its single
// remaining entry is taken in the same cycle. With the receiver ready this
// gives one input per cycle while each input yields at most one result; an
// input that yields two holds off the next input until its second result is taken.
// When the receiver stalls, the buffer fills and tready drops until it drains.
// Synchronous reset disarms the read, clears all counters and the buffer, and
// sets the channel register to 0 and the protocol register to 255.
// The configuration registers are written through cfg_we, cfg_index and
// cfg_data and must only be changed while the block is idle.
module tunnel_message_reassembler_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // capacity, frame_byte, frame_length, frame_protocol,
                                 // frame_channel, zero fill
  input  logic        s_tuser,   // command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // write_offset, write_data, total_size, source_id,
                                 // destination_id, zero fill
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);

  logic [7:0] channel_number;
  logic [7:0] expected_protocol;

  logic       armed;
  logic [8:0] buffer_capacity;
  logic [8:0] fill_count;
  logic [5:0] byte_position;
  logic       frame_accepted;
  logic [7:0] latched_source;
  logic [7:0] latched_destination;

  logic       armed_next;
  logic [8:0] buffer_capacity_next;
  logic [8:0] fill_count_next;
  logic [5:0] byte_position_next;
  logic       frame_accepted_next;
  logic [7:0] latched_source_next;
  logic [7:0] latched_destination_next;

  tmr_pkg::result_t slot0;
  tmr_pkg::result_t slot1;
  logic [1:0]       cnt;

  tmr_pkg::result_t res0;
  tmr_pkg::result_t res1;
  logic [1:0]       res_cnt;

  logic       in_cmd;
  logic [8:0] in_cap;
  logic [7:0] in_byte;
  logic [5:0] in_len;
  logic [7:0] in_proto;
  logic [7:0] in_chan;

  logic push;
  logic pop;

  assign in_cmd   = s_tuser;
  assign in_cap   = s_tdata[8:0];
  assign in_byte  = s_tdata[16:9];
  assign in_len   = s_tdata[22:17];
  assign in_proto = s_tdata[30:23];
  assign in_chan  = s_tdata[38:31];

  assign m_tvalid = (cnt != 2'd0);
  assign s_tready = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);
  assign push     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  assign m_tuser = slot0.kind;
  assign m_tlast = slot0.last;
  assign m_tdata = {7'd0, slot0.destination_id, slot0.source_id, slot0.total_size,
                    slot0.write_data, slot0.write_offset};

  always_comb begin
    logic [5:0]       len_e;
    logic             full;
    logic             hdr_ok;
    logic [5:0]       payload;
    logic             overflow;
    logic             fa0;
    logic             armed0;
    logic [8:0]       fill0;
    logic [8:0]       fill1;
    logic [6:0]       pos_inc;
    tmr_pkg::result_t r;

    armed_next               = armed;
    buffer_capacity_next     = buffer_capacity;
    fill_count_next          = fill_count;
    byte_position_next       = byte_position;
    frame_accepted_next      = frame_accepted;
    latched_source_next      = latched_source;
    latched_destination_next = latched_destination;
    res0                     = '0;
    res1                     = '0;
    res_cnt                  = 2'd0;

    len_e    = (in_len == 6'd0) ? 6'd1 : in_len;
    full     = (len_e == tmr_pkg::LEN_FULL);
    hdr_ok   = armed && (len_e >= tmr_pkg::LEN_HEADER) && (len_e <= tmr_pkg::LEN_FULL) &&
               (in_proto == expected_protocol) && (in_chan == channel_number);
    payload  = len_e - tmr_pkg::LEN_HEADER - (full ? 6'd1 : 6'd0);
    overflow = ({1'b0, fill_count} + 10'(payload)) > {1'b0, buffer_capacity};
    pos_inc  = {1'b0, byte_position} + 7'd1;
    fa0      = frame_accepted;
    armed0   = armed;
    fill0    = fill_count;
    fill1    = fill_count;
    r        = '0;

    if (in_cmd == tmr_pkg::CMD_ARM) begin
      buffer_capacity_next = (in_cap > tmr_pkg::CAP_MAX) ? tmr_pkg::CAP_MAX : in_cap;
      fill_count_next      = 9'd0;
      armed_next           = 1'b1;
      frame_accepted_next  = 1'b0;
    end else begin
      if (byte_position == 6'd0) begin
        fa0 = 1'b0;
        if (hdr_ok) begin
          if (overflow) begin
            armed0 = 1'b0;
            fill0  = 9'd0;
            r      = '0;
            r.kind = tmr_pkg::KIND_ABANDON;
            res0   = r;
            res_cnt = 2'd1;
          end else begin
            fa0 = 1'b1;
          end
        end
      end
      fill1 = fill0;

      if (fa0 && armed0) begin
        if (byte_position == 6'd0) begin
          if (fill0 == 9'd0) begin
            latched_source_next = in_byte;
          end
        end else if (byte_position == 6'd1) begin
          if (fill0 == 9'd0) begin
            latched_destination_next = in_byte;
          end
        end else if (!(full && (pos_inc == {1'b0, len_e})) && (byte_position < len_e)) begin
          if (fill0 < buffer_capacity) begin
            r              = '0;
            r.kind         = tmr_pkg::KIND_WRITE;
            r.write_offset = fill0[7:0];
            r.write_data   = in_byte;
            res0           = r;
            res_cnt        = 2'd1;
            fill1          = fill0 + 9'd1;
          end
        end
      end

      if (pos_inc >= {1'b0, len_e}) begin
        if (fa0 && armed0 && (len_e < tmr_pkg::LEN_FULL)) begin
          r                = '0;
          r.kind           = tmr_pkg::KIND_COMPLETE;
          r.total_size     = fill1;
          r.source_id      = latched_source_next;
          r.destination_id = latched_destination_next;
          if (res_cnt == 2'd0) begin
            res0 = r;
          end else begin
            res1 = r;
          end
          res_cnt = res_cnt + 2'd1;
          armed0  = 1'b0;
        end
        fa0                = 1'b0;
        byte_position_next = 6'd0;
      end else begin
        byte_position_next = pos_inc[5:0];
      end

      armed_next          = armed0;
      fill_count_next     = fill1;
      frame_accepted_next = fa0;
    end

    if (res_cnt == 2'd1) begin
      res0.last = 1'b1;
    end else if (res_cnt == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_number    <= 8'd0;
      expected_protocol <= 8'd255;
    end else if (cfg_we) begin
      unique case (tmr_pkg::reg_index_t'(cfg_index))
        tmr_pkg::REG_CHANNEL:  channel_number    <= cfg_data;
        tmr_pkg::REG_PROTOCOL: expected_protocol <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed               <= 1'b0;
      buffer_capacity     <= 9'd0;
      fill_count          <= 9'd0;
      byte_position       <= 6'd0;
      frame_accepted      <= 1'b0;
      latched_source      <= 8'd0;
      latched_destination <= 8'd0;
    end else if (push) begin
      armed               <= armed_next;
      buffer_capacity     <= buffer_capacity_next;
      fill_count          <= fill_count_next;
      byte_position       <= byte_position_next;
      frame_accepted      <= frame_accepted_next;
      latched_source      <= latched_source_next;
      latched_destination <= latched_destination_next;
    end
  end

  // An accepted input always finds the buffer empty once the head transfer is counted.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push) begin
      cnt <= res_cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

`include "tunnel_message_reassembler_unit_macros.svh"

  `TMR_ASSERT_ALWAYS(a_cnt_range, cnt != 2'd3, "result buffer count out of range")
  `TMR_ASSERT_ALWAYS(a_fill_cap, fill_count <= buffer_capacity, "fill beyond capacity")
  `TMR_ASSERT_NEXT(a_arm, push && (s_tuser == tmr_pkg::CMD_ARM), armed && (fill_count == 9'd0) && (cnt == 2'd0), "arm did not open an empty read")
  `TMR_ASSERT_NEXT(a_end_disarms, push && (res0.kind != tmr_pkg::KIND_WRITE || res_cnt == 2'd2), !armed, "read still armed after completion or abandon")

endmodule
